// ----- rtl/core/kdq_pkg.sv -----
// Shared constants, codes and types of the keyed deque engine.
// Used by kdq_ctrl, kdq_datapath and keyed_deque_engine; depends on nothing.
package kdq_pkg;

   localparam int CAPACITY = 64;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int LINK_W   = $clog2(CAPACITY + 1);

   localparam int OP_W     = 3;
   localparam int ID_W     = 32;
   localparam int REF_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // Link value that points nowhere.
   localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE_ID  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic                latch_in;
      logic                take_stack;
      logic                take_fresh;
      logic                load_slot;
      logic                write_entry;
      logic                fix_links;
      logic                read_end;
      logic                end_tail;
      logic                scan_step;
      logic                unlink;
      logic                set_status;
      logic [STATUS_W-1:0] status;
      logic                load_rsp;
   } kdq_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic            full;
      logic            empty;
      logic            stack_nonempty;
      logic            id_match;
      logic            next_valid;
      logic            rsp_busy;
   } kdq_stat_type;

endpackage

// ----- rtl/core/kdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Holds the slot tables and the free stack; no dependencies.
module kdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/kdq_ctrl.sv -----
// Controller state machine of the keyed deque engine.
// Depends on kdq_pkg; drives kdq_datapath through command and status structs.
module kdq_ctrl
   import kdq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  kdq_stat_type stat,
   output kdq_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_START  = 3'd1;
   localparam logic [2:0] S_TAKE   = 3'd2;
   localparam logic [2:0] S_LINK   = 3'd3;
   localparam logic [2:0] S_FIX    = 3'd4;
   localparam logic [2:0] S_SCAN   = 3'd5;
   localparam logic [2:0] S_UNLINK = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch_in = 1'b1;
               state_in     = S_START;
            end
         end
         S_START: begin
            case (stat.opcode)
               OP_PUSH_FRONT, OP_PUSH_BACK: begin
                  if (stat.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                     state_in       = S_DONE;
                  end else if (stat.stack_nonempty) begin
                     cmd.take_stack = 1'b1;
                     state_in       = S_TAKE;
                  end else begin
                     cmd.take_fresh = 1'b1;
                     state_in       = S_LINK;
                  end
               end
               OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_ID: begin
                  if (stat.empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                     state_in       = S_DONE;
                  end else begin
                     cmd.read_end = 1'b1;
                     cmd.end_tail = (stat.opcode == OP_POP_BACK);
                     state_in     = (stat.opcode == OP_REMOVE_ID) ? S_SCAN : S_UNLINK;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_TAKE: begin
            cmd.load_slot = 1'b1;
            state_in      = S_LINK;
         end
         S_LINK: begin
            cmd.write_entry = 1'b1;
            state_in        = S_FIX;
         end
         S_FIX: begin
            cmd.fix_links = 1'b1;
            state_in      = S_DONE;
         end
         S_SCAN: begin
            // walk one entry per cycle from the head
            if (stat.id_match) begin
               state_in = S_UNLINK;
            end else if (stat.next_valid) begin
               cmd.scan_step = 1'b1;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NOTFOUND;
               state_in       = S_DONE;
            end
         end
         S_UNLINK: begin
            cmd.unlink = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_scan_only_remove: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (stat.opcode == OP_REMOVE_ID))
      else $error("scan running for an operation other than remove by id");
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LINK) |-> !stat.full)
      else $error("entry written into a full table");
   a_unlink_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.unlink |-> !stat.empty)
      else $error("unlink issued on an empty list");
`endif

endmodule

// ----- rtl/core/kdq_datapath.sv -----
// Datapath of the keyed deque engine: slot tables, free stack, list pointers
// and the result register. Depends on kdq_pkg and kdq_ram.
module kdq_datapath
   import kdq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  kdq_cmd_type                cmd,
   output kdq_stat_type               stat,
   input  logic [OP_W-1:0]            in_opcode,
   input  logic signed [ID_W-1:0]     in_task_id,
   input  logic [REF_W-1:0]           in_task_ref,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [ID_W-1:0]     rsp_out_id,
   output logic [REF_W-1:0]           rsp_out_ref,
   output logic [COUNT_W-1:0]         rsp_entry_count
);

   // latched request
   logic [OP_W-1:0]        op_ff;
   logic signed [ID_W-1:0] key_ff;
   logic [REF_W-1:0]       ref_ff;

   // list control
   logic [LINK_W-1:0] head_ff, head_in;
   logic [LINK_W-1:0] tail_ff, tail_in;
   logic [LINK_W-1:0] used_ff, used_in;
   logic [LINK_W-1:0] top_ff, top_in;
   logic [LINK_W-1:0] fresh_ff, fresh_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   // pending result
   logic [STATUS_W-1:0]    res_status_ff;
   logic signed [ID_W-1:0] res_id_ff;
   logic [REF_W-1:0]       res_ref_ff;

   // output register
   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic signed [ID_W-1:0] rsp_id_ff;
   logic [REF_W-1:0]       rsp_ref_ff;
   logic [COUNT_W-1:0]     rsp_count_ff;

   // memories
   logic [ID_W-1:0]   id_rdata;
   logic [REF_W-1:0]  ref_rdata;
   logic [LINK_W-1:0] next_rdata;
   logic [LINK_W-1:0] prev_rdata;
   logic [SLOT_W-1:0] free_rdata;

   logic              entry_re;
   logic [SLOT_W-1:0] entry_raddr;
   logic [LINK_W-1:0] end_slot;

   logic              next_we;
   logic [SLOT_W-1:0] next_waddr;
   logic [LINK_W-1:0] next_wdata;
   logic              prev_we;
   logic [SLOT_W-1:0] prev_waddr;
   logic [LINK_W-1:0] prev_wdata;

   logic [LINK_W-1:0] top_dec;
   logic [LINK_W-1:0] slot_link;
   logic              push_back;
   logic              head_valid;
   logic              tail_valid;
   logic              p_valid;
   logic              n_valid;

   assign push_back  = (op_ff == OP_PUSH_BACK);
   assign slot_link  = LINK_W'(slot_ff);
   assign head_valid = (head_ff < NIL);
   assign tail_valid = (tail_ff < NIL);
   assign p_valid    = (prev_rdata < NIL);
   assign n_valid    = (next_rdata < NIL);
   assign top_dec    = top_ff - 1'b1;
   assign end_slot   = cmd.end_tail ? tail_ff : head_ff;

   assign entry_re    = cmd.read_end | cmd.scan_step;
   assign entry_raddr = cmd.read_end ? end_slot[SLOT_W-1:0] : next_rdata[SLOT_W-1:0];

   always_comb begin
      next_we    = 1'b0;
      next_waddr = slot_ff;
      next_wdata = NIL;
      if (cmd.write_entry) begin
         next_we    = 1'b1;
         next_wdata = push_back ? NIL : head_ff;
      end else if (cmd.fix_links && push_back && tail_valid) begin
         next_we    = 1'b1;
         next_waddr = tail_ff[SLOT_W-1:0];
         next_wdata = slot_link;
      end else if (cmd.unlink && p_valid) begin
         next_we    = 1'b1;
         next_waddr = prev_rdata[SLOT_W-1:0];
         next_wdata = next_rdata;
      end
   end

   always_comb begin
      prev_we    = 1'b0;
      prev_waddr = slot_ff;
      prev_wdata = NIL;
      if (cmd.write_entry) begin
         prev_we    = 1'b1;
         prev_wdata = push_back ? tail_ff : NIL;
      end else if (cmd.fix_links && !push_back && head_valid) begin
         prev_we    = 1'b1;
         prev_waddr = head_ff[SLOT_W-1:0];
         prev_wdata = slot_link;
      end else if (cmd.unlink && n_valid) begin
         prev_we    = 1'b1;
         prev_waddr = next_rdata[SLOT_W-1:0];
         prev_wdata = prev_rdata;
      end
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      used_in  = used_ff;
      top_in   = top_ff;
      fresh_in = fresh_ff;
      slot_in  = slot_ff;
      if (cmd.take_stack) begin
         top_in = top_dec;
      end
      if (cmd.take_fresh) begin
         slot_in  = fresh_ff[SLOT_W-1:0];
         fresh_in = fresh_ff + 1'b1;
      end
      if (cmd.load_slot) begin
         slot_in = free_rdata;
      end
      if (cmd.read_end) begin
         slot_in = end_slot[SLOT_W-1:0];
      end
      if (cmd.scan_step) begin
         slot_in = next_rdata[SLOT_W-1:0];
      end
      if (cmd.fix_links) begin
         used_in = used_ff + 1'b1;
         if (push_back) begin
            tail_in = slot_link;
            if (!tail_valid) begin
               head_in = slot_link;
            end
         end else begin
            head_in = slot_link;
            if (!head_valid) begin
               tail_in = slot_link;
            end
         end
      end
      if (cmd.unlink) begin
         used_in = used_ff - 1'b1;
         top_in  = top_ff + 1'b1;
         head_in = p_valid ? head_ff : next_rdata;
         tail_in = n_valid ? tail_ff : prev_rdata;
         // last entry gone: both ends back to nowhere
         if (used_ff == LINK_W'(1)) begin
            head_in = NIL;
            tail_in = NIL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= NIL;
         tail_ff      <= NIL;
         used_ff      <= '0;
         top_ff       <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         used_ff  <= used_in;
         top_ff   <= top_in;
         fresh_ff <= fresh_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (cmd.latch_in) begin
         op_ff         <= in_opcode;
         key_ff        <= in_task_id;
         ref_ff        <= in_task_ref;
         res_status_ff <= ST_OK;
         res_id_ff     <= '0;
         res_ref_ff    <= '0;
      end
      if (cmd.set_status) begin
         res_status_ff <= cmd.status;
      end
      if (cmd.unlink) begin
         res_id_ff  <= signed'(id_rdata);
         res_ref_ff <= ref_rdata;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_id_ff     <= res_id_ff;
         rsp_ref_ff    <= res_ref_ff;
         rsp_count_ff  <= COUNT_W'(used_ff);
      end
   end

   kdq_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_id_ram (
      .clock   (clock),
      .wr_en   (cmd.write_entry),
      .wr_addr (slot_ff),
      .wr_data (key_ff),
      .rd_en   (entry_re),
      .rd_addr (entry_raddr),
      .rd_data (id_rdata)
   );

   kdq_ram #(.WIDTH(REF_W), .DEPTH(CAPACITY)) u_ref_ram (
      .clock   (clock),
      .wr_en   (cmd.write_entry),
      .wr_addr (slot_ff),
      .wr_data (ref_ff),
      .rd_en   (entry_re),
      .rd_addr (entry_raddr),
      .rd_data (ref_rdata)
   );

   kdq_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_en   (entry_re),
      .rd_addr (entry_raddr),
      .rd_data (next_rdata)
   );

   kdq_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_en   (entry_re),
      .rd_addr (entry_raddr),
      .rd_data (prev_rdata)
   );

   // returned slots; never-used slots come from the fresh counter instead
   kdq_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free_ram (
      .clock   (clock),
      .wr_en   (cmd.unlink),
      .wr_addr (top_ff[SLOT_W-1:0]),
      .wr_data (slot_ff),
      .rd_en   (cmd.take_stack),
      .rd_addr (top_dec[SLOT_W-1:0]),
      .rd_data (free_rdata)
   );

   assign stat.opcode         = op_ff;
   assign stat.full           = (used_ff == LINK_W'(CAPACITY));
   assign stat.empty          = (used_ff == '0);
   assign stat.stack_nonempty = (top_ff != '0);
   assign stat.id_match       = (signed'(id_rdata) == key_ff);
   assign stat.next_valid     = n_valid;
   assign stat.rsp_busy       = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_id      = rsp_id_ff;
   assign rsp_out_ref     = rsp_ref_ff;
   assign rsp_entry_count = rsp_count_ff;

`ifndef ASSERT_OFF
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      used_ff <= LINK_W'(CAPACITY))
      else $error("entry count above capacity");
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      (used_ff == '0) == (head_ff == NIL))
      else $error("head pointer disagrees with entry count");
   a_ends_paired: assert property (@(posedge clock) disable iff (reset)
      (head_ff == NIL) == (tail_ff == NIL))
      else $error("only one end of the list is null");
   // every slot handed out by the fresh counter is either in use or on the stack
   a_slot_balance: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> ((LINK_W+1)'(fresh_ff)
                        == (LINK_W+1)'(top_ff) + (LINK_W+1)'(used_ff)))
      else $error("slot accounting lost a slot");
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_rsp && res_status_ff == ST_FULL) |-> stat.full)
      else $error("full status reported on a table with room");
`endif

endmodule

// ----- rtl/core/keyed_deque_engine.sv -----
// Top level of the keyed deque engine: stream ports around the controller
// and datapath. Depends on kdq_pkg, kdq_ctrl, kdq_datapath and kdq_ram.

// A bounded double-ended queue of up to 64 entries (task id plus handle),
// kept as a doubly linked list over slot RAMs with a free-slot stack. One
// word is taken at a time; each word yields exactly one result word. A push
// that reuses a freed slot first reads it from the stack; remove by id walks
// from the front until the id matches or the list ends. The walk reads one
// linked entry per cycle through the single read port of the link RAMs. Push
// into a full table returns status full, pops and remove on an empty list
// return empty, a missing id returns not found; in every such case nothing
// changes. Opcodes 5 to 7 return ok with zero id and handle. The next word
// is accepted once the result is loaded, even while that result still waits
// on rsp_tready. No clearing pass is needed after reset.
module keyed_deque_engine
   import kdq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] task_id, [63:32] task_ref
   input  logic [2:0]  req_tuser,   // [2:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] out_id, [63:32] out_ref,
                                    // [70:64] entry_count, [71] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   kdq_cmd_type            cmd;
   kdq_stat_type           stat;
   logic signed [ID_W-1:0] out_id;
   logic [REF_W-1:0]       out_ref;
   logic [COUNT_W-1:0]     entry_count;

   kdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   kdq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .in_opcode       (req_tuser),
      .in_task_id      (signed'(req_tdata[31:0])),
      .in_task_ref     (req_tdata[63:32]),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_status      (rsp_tuser),
      .rsp_out_id      (out_id),
      .rsp_out_ref     (out_ref),
      .rsp_entry_count (entry_count)
   );

   assign rsp_tdata = {1'b0, entry_count, out_ref, out_id};

endmodule

// ----- dv/keyed_deque_engine_tb.sv -----
// Self-checking testbench for keyed_deque_engine: a directed table, then random
// fill, drain and mixed phases, scored against a queue-based deque predictor or typed results.
// Depends on kdq_pkg and the keyed_deque_engine RTL.
module keyed_deque_engine_tb
   import kdq_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS = 1650;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_WAIT   = 80;
   localparam int HOLD_CYCLES  = 250;
   localparam int DIR_ROWS     = 25;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     id;
      logic [REF_W-1:0]    handle;
      logic [COUNT_W-1:0]  count;
   } deque_rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [REF_W-1:0] handle;
   } task_entry_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [ID_W-1:0]  id;
      logic [REF_W-1:0] handle;
      logic             typed;
      deque_rsp_type    rsp;
   } dir_row_type;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   task_entry_type deque_model[$];
   deque_rsp_type  pending_rsp[$];
   int             mismatches = 0;
   int             cycles = 0;
   bit             quiet = 1'b0;

   // Expected results typed in only where they are obvious; zero rsp otherwise.
   dir_row_type dir_table [DIR_ROWS] = '{
      '{OP_POP_FRONT,  32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0, 32'h0, 7'd0}},
      '{OP_POP_BACK,   32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0, 32'h0, 7'd0}},
      '{OP_REMOVE_ID,  32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0, 32'h0, 7'd0}},
      '{3'd5,          32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'h0, 32'h0, 7'd0}},
      '{3'd7,          32'h1234_5678, 32'h9ABC_DEF0, 1'b1, '{ST_OK, 32'h0, 32'h0, 7'd0}},
      '{OP_PUSH_FRONT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'h0, 32'h0, 7'd1}},
      '{OP_PUSH_BACK,  32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0, 32'h0, 7'd2}},
      '{OP_PUSH_FRONT, 32'h0000_0005, 32'h0000_1111, 1'b0, '0},
      '{OP_PUSH_BACK,  32'h0000_0005, 32'h0000_2222, 1'b0, '0},
      '{OP_PUSH_BACK,  32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b0, '0},
      '{OP_REMOVE_ID,  32'h0000_3039, 32'h0000_0000, 1'b0, '0},
      '{OP_REMOVE_ID,  32'h0000_0005, 32'h0000_0000, 1'b0, '0},
      '{OP_REMOVE_ID,  32'h0000_0005, 32'h0000_0000, 1'b0, '0},
      '{3'd6,          32'h5555_5555, 32'h5555_5555, 1'b0, '0},
      '{OP_POP_FRONT,  32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{OP_POP_BACK,   32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{OP_POP_BACK,   32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{OP_POP_FRONT,  32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0, 32'h0, 7'd0}},
      '{OP_PUSH_BACK,  32'h0000_0000, 32'h5555_5555, 1'b0, '0},
      '{OP_POP_FRONT,  32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'h0000_0001, 32'h0000_0101, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'h0000_0002, 32'h0000_0202, 1'b0, '0},
      '{OP_REMOVE_ID,  32'h0000_0001, 32'h0000_0000, 1'b0, '0},
      '{OP_REMOVE_ID,  32'h0000_0002, 32'h0000_0000, 1'b0, '0},
      '{OP_REMOVE_ID,  32'h0000_0002, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0, 32'h0, 7'd0}}
   };

   keyed_deque_engine u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  pending_rsp.size());
         $display("keyed_deque_engine_tb failed");
         $finish;
      end
   end

   // Apply one operation to the deque model and return the result it yields.
   function automatic deque_rsp_type apply_deque_op(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                                     logic [REF_W-1:0] handle);
      deque_rsp_type  res;
      task_entry_type ent;
      int             hit;
      res = '0;
      res.status = ST_OK;
      ent.id = id;
      ent.handle = handle;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (deque_model.size() >= CAPACITY) res.status = ST_FULL;
            else if (op == OP_PUSH_FRONT) deque_model.push_front(ent);
            else deque_model.push_back(ent);
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (deque_model.size() == 0) begin
               res.status = ST_EMPTY;
            end else begin
               ent = (op == OP_POP_FRONT) ? deque_model.pop_front() : deque_model.pop_back();
               res.id = ent.id;
               res.handle = ent.handle;
            end
         end
         OP_REMOVE_ID: begin
            hit = -1;
            for (int i = 0; i < deque_model.size(); i++)
               if (hit < 0 && deque_model[i].id == id) hit = i;
            if (deque_model.size() == 0) begin
               res.status = ST_EMPTY;
            end else if (hit < 0) begin
               res.status = ST_NOTFOUND;
            end else begin
               res.id = deque_model[hit].id;
               res.handle = deque_model[hit].handle;
               deque_model.delete(hit);
            end
         end
         default: ;
      endcase
      res.count = COUNT_W'(deque_model.size());
      return res;
   endfunction

   // Offer one word, wait for its handshake, then queue what it must return.
   task automatic send_word(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                            logic [REF_W-1:0] handle, bit typed, deque_rsp_type typed_rsp);
      int            gap;
      deque_rsp_type predicted;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {handle, id};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      predicted = apply_deque_op(op, id, handle);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   function automatic logic [ID_W-1:0] pick_id(bit for_remove);
      int r;
      r = $urandom_range(0, 99);
      if (for_remove && deque_model.size() != 0 && r < 60)
         return deque_model[$urandom_range(0, deque_model.size() - 1)].id;
      r = $urandom_range(0, 99);
      if (r < 45) return ID_W'($urandom_range(0, 7));
      if (r < 60) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [OP_W-1:0] pick_op(traffic_mix_type mix);
      int r;
      int push_pct;
      int pop_pct;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  begin push_pct = 80; pop_pct = 10; end
         MIX_DRAIN: begin push_pct = 20; pop_pct = 55; end
         default:   begin push_pct = 45; pop_pct = 30; end
      endcase
      if (r < push_pct) return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      if (r < push_pct + pop_pct) return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      return OP_REMOVE_ID;
   endfunction

   // Result side: random stalls, plus two long hold-offs that back up the block.
   initial begin
      int gap;
      int seen;
      seen = 0;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (seen == 300 || seen == 1100) gap = HOLD_CYCLES;
         else gap = quiet ? 0 : $urandom_range(0, 3);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         seen++;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      deque_rsp_type want;
      deque_rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser;
         got.id     = rsp_tdata[31:0];
         got.handle = rsp_tdata[63:32];
         got.count  = rsp_tdata[70:64];
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result status=%0d id=%h handle=%h count=%0d",
                        $realtime, got.status, got.id, got.handle, got.count);
         end else begin
            want = pending_rsp.pop_front();
            if (got.status !== want.status || got.id !== want.id ||
                got.handle !== want.handle || got.count !== want.count ||
                rsp_tdata[71] !== 1'b0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: mismatch exp status=%0d id=%h handle=%h count=%0d",
                           $realtime, want.status, want.id, want.handle, want.count);
                  $display("   got status=%0d id=%h handle=%h count=%0d pad=%b",
                           got.status, got.id, got.handle, got.count, rsp_tdata[71]);
               end
            end
         end
      end
   end

   initial begin
      int              sent;
      int              phase_len;
      traffic_mix_type mix;
      logic [OP_W-1:0] op;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_table[i])
         send_word(dir_table[i].op, dir_table[i].id, dir_table[i].handle,
                   dir_table[i].typed, dir_table[i].rsp);

      sent = 0;
      while (sent < RANDOM_WORDS) begin
         mix = traffic_mix_type'($urandom_range(0, 2));
         phase_len = $urandom_range(40, 120);
         // hold the sender until the block has answered everything
         if ($urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            wait (pending_rsp.size() == 0);
            @(negedge clock);
         end
         quiet = ($urandom_range(0, 4) == 0);
         repeat (phase_len) begin
            if ($urandom_range(0, 49) == 0) begin
               op = OP_W'($urandom_range(5, 7));
               send_word(op, $urandom, $urandom, 1'b0, '0);
            end else begin
               op = pick_op(mix);
               send_word(op, pick_id(op == OP_REMOVE_ID), $urandom, 1'b0, '0);
               sent++;
            end
         end
      end
      quiet = 1'b0;
      req_tvalid <= 1'b0;

      wait (pending_rsp.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0)
         $display("keyed_deque_engine_tb passed");
      else
         $display("keyed_deque_engine_tb failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/kdq_pkg.sv
rtl/core/kdq_ram.sv
rtl/core/kdq_ctrl.sv
rtl/core/kdq_datapath.sv
rtl/core/keyed_deque_engine.sv
dv/keyed_deque_engine_tb.sv
